@@ rtl/ppuv_pkg.sv @@
// shared constants, types and saturation helper for the position to uv pipeline
// no dependencies; every other file refers to it by scoped names
package ppuv_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_LANES = 4;
  localparam int IDX_W     = 6;
  localparam int MAT_IDX_W = 4;
  localparam int MAT_SIZE  = 16;
  localparam int FMT_W     = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int WIDE_W    = PROD_W + 2;
  localparam int DVD_W     = DATA_W + FRAC_BITS;

  localparam logic [DATA_W-1:0] ONE_Q =
    {{(DATA_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XFORM = 1'b1;

  localparam logic [1:0] MAT_CAMERA = 2'd0;
  localparam logic [1:0] MAT_PROJ   = 2'd1;
  localparam logic [1:0] MAT_FORMAT = 2'd2;

  localparam logic REG_FORMAT_WIDTH  = 1'b0;
  localparam logic REG_FORMAT_HEIGHT = 1'b1;

  typedef enum logic {
    DIV_W,
    DIV_NORM
  } div_mode_t;

  typedef struct packed {
    logic                                 valid;
    logic                                 load;
    logic [IDX_W-1:0]                     idx;
    logic [DATA_W-1:0]                    value;
    logic [NUM_LANES-1:0][DATA_W-1:0]     vec;
  } item_t;

  function automatic logic [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-DATA_W:0] top;
    top = v[WIDE_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return v[DATA_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/ppuv_if.sv @@
// valid/ready channel interfaces for the position input and the uv result
// depends on ppuv_pkg for field widths
interface ppuv_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [ppuv_pkg::IDX_W-1:0]     coef_index;
  logic signed [ppuv_pkg::DATA_W-1:0] coef_value;
  logic signed [ppuv_pkg::DATA_W-1:0] pos_x;
  logic signed [ppuv_pkg::DATA_W-1:0] pos_y;
  logic signed [ppuv_pkg::DATA_W-1:0] pos_z;
  logic signed [ppuv_pkg::DATA_W-1:0] pos_w;

  modport source (output valid, command, coef_index, coef_value, pos_x, pos_y, pos_z, pos_w,
                  input ready);
  modport sink (input valid, command, coef_index, coef_value, pos_x, pos_y, pos_z, pos_w,
                output ready);
endinterface

interface ppuv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ppuv_pkg::DATA_W-1:0] out_u;
  logic signed [ppuv_pkg::DATA_W-1:0] out_v;
  logic signed [ppuv_pkg::DATA_W-1:0] out_depth;
  logic signed [ppuv_pkg::DATA_W-1:0] out_weight;

  modport source (output valid, out_u, out_v, out_depth, out_weight, input ready);
  modport sink (input valid, out_u, out_v, out_depth, out_weight, output ready);
endinterface

@@ rtl/ppuv_mat.sv @@
// one 4x4 matrix times vector unit: coefficient registers, multiply, two add stages
// depends on ppuv_pkg
module ppuv_mat (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [1:0]      sel,
  input  ppuv_pkg::item_t in_item,
  output ppuv_pkg::item_t out_item
);

  logic [ppuv_pkg::DATA_W-1:0]        coef [ppuv_pkg::MAT_SIZE];
  logic signed [ppuv_pkg::PROD_W-1:0] prod [ppuv_pkg::MAT_SIZE];
  logic signed [ppuv_pkg::PROD_W:0]   psum [ppuv_pkg::MAT_SIZE/2];
  ppuv_pkg::item_t                    s1_item;
  ppuv_pkg::item_t                    s2_item;
  ppuv_pkg::item_t                    out_next;
  logic                               coef_we;

  // a load word writes here as it passes, so it stays in order with transforms
  assign coef_we = en && in_item.valid && in_item.load &&
                   (in_item.idx[ppuv_pkg::IDX_W-1:ppuv_pkg::MAT_IDX_W] == sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppuv_pkg::MAT_SIZE; i++) begin
        coef[i] <= ((i >> 2) == (i & 3)) ? ppuv_pkg::ONE_Q : '0;
      end
    end else if (coef_we) begin
      coef[in_item.idx[ppuv_pkg::MAT_IDX_W-1:0]] <= in_item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ppuv_pkg::MAT_SIZE; i++) begin
        prod[i] <= $signed(coef[i]) * $signed(in_item.vec[i & 3]);
      end
      for (int j = 0; j < ppuv_pkg::MAT_SIZE/2; j++) begin
        psum[j] <= prod[2*j] + prod[2*j+1];
      end
    end
    if (rst) begin
      s1_item.valid  <= 1'b0;
      s2_item.valid  <= 1'b0;
      out_item.valid <= 1'b0;
    end else if (en) begin
      s1_item  <= in_item;
      s2_item  <= s1_item;
      out_item <= out_next;
    end
  end

  // exact row sum, floor shift, saturate
  always_comb begin
    logic signed [ppuv_pkg::WIDE_W-1:0] sum;
    out_next = s2_item;
    for (int r = 0; r < ppuv_pkg::NUM_LANES; r++) begin
      sum = ppuv_pkg::WIDE_W'(psum[2*r]) + ppuv_pkg::WIDE_W'(psum[2*r+1]);
      out_next.vec[r] = ppuv_pkg::sat_wide(sum >>> ppuv_pkg::FRAC_BITS);
    end
  end

endmodule

@@ rtl/ppuv_div.sv @@
// pipelined restoring divider over four lanes, one quotient bit per stage
// w mode divides each component by w; norm mode divides u, v by the format size
// depends on ppuv_pkg
module ppuv_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  ppuv_pkg::div_mode_t           mode,
  input  logic [ppuv_pkg::FMT_W-1:0]    fmt_width,
  input  logic [ppuv_pkg::FMT_W-1:0]    fmt_height,
  input  ppuv_pkg::item_t               in_item,
  output ppuv_pkg::item_t               out_item
);

  localparam int NSTG = ppuv_pkg::DVD_W + 1;

  typedef struct packed {
    logic [ppuv_pkg::DVD_W-1:0]  dq;
    logic [ppuv_pkg::DATA_W-1:0] rem;
    logic [ppuv_pkg::DATA_W-1:0] dvs;
    logic                        neg;
    logic                        act;
  } lane_t;

  lane_t           lane [NSTG][ppuv_pkg::NUM_LANES];
  ppuv_pkg::item_t item [NSTG];
  lane_t           pre  [ppuv_pkg::NUM_LANES];
  ppuv_pkg::item_t out_next;

  // operand prep: magnitudes, sign, divisor
  always_comb begin
    for (int l = 0; l < ppuv_pkg::NUM_LANES; l++) begin
      logic [ppuv_pkg::DATA_W-1:0] c;
      logic [ppuv_pkg::DATA_W-1:0] w;
      logic [ppuv_pkg::DATA_W-1:0] mag_c;
      logic [ppuv_pkg::DATA_W-1:0] mag_w;
      logic [ppuv_pkg::FMT_W-1:0]  d;
      c     = in_item.vec[l];
      w     = in_item.vec[ppuv_pkg::NUM_LANES-1];
      mag_c = c[ppuv_pkg::DATA_W-1] ? (~c + 1'b1) : c;
      mag_w = w[ppuv_pkg::DATA_W-1] ? (~w + 1'b1) : w;
      d     = (l == 0) ? fmt_width : fmt_height;
      if (d == '0) begin
        d = ppuv_pkg::FMT_W'(1);
      end
      pre[l].rem = '0;
      unique case (mode)
        ppuv_pkg::DIV_W: begin
          pre[l].dq  = {mag_c, {ppuv_pkg::FRAC_BITS{1'b0}}};
          pre[l].dvs = mag_w;
          pre[l].neg = c[ppuv_pkg::DATA_W-1] ^ w[ppuv_pkg::DATA_W-1];
          pre[l].act = |w;
        end
        ppuv_pkg::DIV_NORM: begin
          pre[l].dq  = {{ppuv_pkg::FRAC_BITS{1'b0}}, mag_c};
          pre[l].dvs = {{(ppuv_pkg::DATA_W-ppuv_pkg::FMT_W){1'b0}}, d};
          pre[l].neg = c[ppuv_pkg::DATA_W-1];
          pre[l].act = (l < 2);
        end
        default: begin
          pre[l] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < ppuv_pkg::NUM_LANES; l++) begin
        lane[0][l] <= pre[l];
      end
    end
    if (rst) begin
      item[0].valid <= 1'b0;
    end else if (en) begin
      item[0] <= in_item;
    end
  end

  for (genvar s = 1; s < NSTG; s++) begin : g_step
    lane_t step_next [ppuv_pkg::NUM_LANES];

    always_comb begin
      for (int l = 0; l < ppuv_pkg::NUM_LANES; l++) begin
        logic [ppuv_pkg::DATA_W:0] t;
        logic                      ge;
        t  = {lane[s-1][l].rem, lane[s-1][l].dq[ppuv_pkg::DVD_W-1]};
        ge = t >= {1'b0, lane[s-1][l].dvs};
        if (ge) begin
          t = t - {1'b0, lane[s-1][l].dvs};
        end
        step_next[l]     = lane[s-1][l];
        step_next[l].rem = t[ppuv_pkg::DATA_W-1:0];
        step_next[l].dq  = {lane[s-1][l].dq[ppuv_pkg::DVD_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < ppuv_pkg::NUM_LANES; l++) begin
          lane[s][l] <= step_next[l];
        end
      end
      if (rst) begin
        item[s].valid <= 1'b0;
      end else if (en) begin
        item[s] <= item[s-1];
      end
    end
  end

  // apply sign, saturate; skipped lanes pass unchanged
  always_comb begin
    out_next = item[NSTG-1];
    for (int l = 0; l < ppuv_pkg::NUM_LANES; l++) begin
      logic signed [ppuv_pkg::WIDE_W-1:0] q;
      q = {{(ppuv_pkg::WIDE_W-ppuv_pkg::DVD_W){1'b0}}, lane[NSTG-1][l].dq};
      if (lane[NSTG-1][l].neg) begin
        q = -q;
      end
      if (lane[NSTG-1][l].act) begin
        out_next.vec[l] = ppuv_pkg::sat_wide(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (en) begin
      out_item <= out_next;
    end
  end

endmodule

@@ rtl/projective_position_to_uv.sv @@
// top level: camera, projection and format matrices with w divides and uv normalize
// depends on ppuv_pkg, ppuv_if, ppuv_mat, ppuv_div
//
//   port      dir  handshake      carries
//   pix_in    in   valid/ready    command, coef_index, coef_value, pos_x..pos_w
//   uv_out    out  valid/ready    out_u, out_v, out_depth, out_weight
//   cfg_*     in   cfg_we only    format_width (index 0), format_height (index 1)
//
// one word per cycle unless uv_out stalls; three matrix units of 3 stages, three
// dividers of 50 stages (prep, quotient steps, output) and the output register.
// load words travel the pipe and write their matrix on passing; they give no result.
// a stalled output freezes the whole pipe, nothing is dropped or repeated.
// reset is synchronous and restores identity matrices and format size 1.
module projective_position_to_uv (
  input  logic                            clk,
  input  logic                            rst,
  ppuv_in_if.sink                         pix_in,
  ppuv_out_if.source                      uv_out,
  input  logic                            cfg_we,
  input  logic                            cfg_addr,
  input  logic [ppuv_pkg::FMT_W-1:0]      cfg_data
);

  logic                         en;
  logic                         out_valid;
  logic [ppuv_pkg::DATA_W-1:0]  res_u;
  logic [ppuv_pkg::DATA_W-1:0]  res_v;
  logic [ppuv_pkg::DATA_W-1:0]  res_depth;
  logic [ppuv_pkg::DATA_W-1:0]  res_weight;
  logic [ppuv_pkg::FMT_W-1:0]   format_width;
  logic [ppuv_pkg::FMT_W-1:0]   format_height;
  ppuv_pkg::item_t              in_item;
  ppuv_pkg::item_t              cam_item;
  ppuv_pkg::item_t              proj_item;
  ppuv_pkg::item_t              pdiv_item;
  ppuv_pkg::item_t              fmt_item;
  ppuv_pkg::item_t              fdiv_item;
  ppuv_pkg::item_t              norm_item;

  assign en           = !out_valid || uv_out.ready;
  assign pix_in.ready = en;

  always_comb begin
    in_item        = '0;
    in_item.valid  = pix_in.valid;
    in_item.load   = (pix_in.command == ppuv_pkg::CMD_LOAD);
    in_item.idx    = pix_in.coef_index;
    in_item.value  = pix_in.coef_value;
    in_item.vec[0] = pix_in.pos_x;
    in_item.vec[1] = pix_in.pos_y;
    in_item.vec[2] = pix_in.pos_z;
    in_item.vec[3] = pix_in.pos_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_width  <= ppuv_pkg::FMT_W'(1);
      format_height <= ppuv_pkg::FMT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ppuv_pkg::REG_FORMAT_WIDTH:  format_width  <= cfg_data;
        ppuv_pkg::REG_FORMAT_HEIGHT: format_height <= cfg_data;
        default: ;
      endcase
    end
  end

  ppuv_mat u_cam (
    .clk(clk), .rst(rst), .en(en), .sel(ppuv_pkg::MAT_CAMERA),
    .in_item(in_item), .out_item(cam_item)
  );

  ppuv_mat u_proj (
    .clk(clk), .rst(rst), .en(en), .sel(ppuv_pkg::MAT_PROJ),
    .in_item(cam_item), .out_item(proj_item)
  );

  ppuv_div u_pdiv (
    .clk(clk), .rst(rst), .en(en), .mode(ppuv_pkg::DIV_W),
    .fmt_width(format_width), .fmt_height(format_height),
    .in_item(proj_item), .out_item(pdiv_item)
  );

  ppuv_mat u_fmt (
    .clk(clk), .rst(rst), .en(en), .sel(ppuv_pkg::MAT_FORMAT),
    .in_item(pdiv_item), .out_item(fmt_item)
  );

  ppuv_div u_fdiv (
    .clk(clk), .rst(rst), .en(en), .mode(ppuv_pkg::DIV_W),
    .fmt_width(format_width), .fmt_height(format_height),
    .in_item(fmt_item), .out_item(fdiv_item)
  );

  ppuv_div u_norm (
    .clk(clk), .rst(rst), .en(en), .mode(ppuv_pkg::DIV_NORM),
    .fmt_width(format_width), .fmt_height(format_height),
    .in_item(fdiv_item), .out_item(norm_item)
  );

  // load words end here
  always_ff @(posedge clk) begin
    if (en) begin
      res_u      <= norm_item.vec[0];
      res_v      <= norm_item.vec[1];
      res_depth  <= norm_item.vec[2];
      res_weight <= norm_item.vec[3];
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= norm_item.valid && !norm_item.load;
    end
  end

  assign uv_out.valid      = out_valid;
  assign uv_out.out_u      = res_u;
  assign uv_out.out_v      = res_v;
  assign uv_out.out_depth  = res_depth;
  assign uv_out.out_weight = res_weight;

endmodule

@@ dv/tb_top.sv @@
// testbench for projective_position_to_uv: directed words, then random phases,
// each result word checked in order against a given expectation or a fixed point predictor of the block
// depends on ppuv_pkg and ppuv_if from the rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int Q1 = 65536;
  localparam logic signed [31:0] MAXQ = 32'sh7fffffff;
  localparam logic signed [31:0] MINQ = 32'sh80000000;
  localparam int DRAIN = 170;

  typedef logic signed [31:0] vec_t [4];
  typedef struct {
    logic signed [31:0] u, v, d, w;
  } uv_t;
  typedef struct {
    logic cmd;
    logic [5:0] idx;
    logic signed [31:0] val;
    vec_t pos;
    bit typed;
    uv_t want;
  } row_t;

  logic clk, rst;
  logic cfg_we, cfg_addr;
  logic [15:0] cfg_data;

  ppuv_in_if pix_in_if ();
  ppuv_out_if uv_out_if ();

  projective_position_to_uv dut (
    .clk(clk), .rst(rst), .pix_in(pix_in_if), .uv_out(uv_out_if),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [31:0] coef_mem [48];
  logic [15:0] fmt_w, fmt_h;
  uv_t pending_uv [$];
  row_t dir_rows [$];
  int tx_idle, rx_idle;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [31:0] sat(input logic signed [65:0] x);
    if (x > 66'sh7fffffff) return MAXQ;
    if (x < -66'sh80000000) return MINQ;
    return x[31:0];
  endfunction

  function automatic void mat_mul(input int base, input vec_t vin, output vec_t vout);
    logic signed [65:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        acc = acc + 66'(coef_mem[base + 4 * r + k]) * 66'(vin[k]);
      end
      vout[r] = sat(acc >>> ppuv_pkg::FRAC_BITS);
    end
  endfunction

  function automatic void w_div(inout vec_t vv);
    logic signed [65:0] wq;
    wq = 66'(vv[3]);
    if (wq == 0) return;
    for (int i = 0; i < 4; i++) begin
      vv[i] = sat((66'(vv[i]) <<< ppuv_pkg::FRAC_BITS) / wq);
    end
  endfunction

  function automatic uv_t project_pos(input vec_t p);
    vec_t v1, v2, v3;
    uv_t res;
    logic signed [65:0] wd, ht;
    mat_mul(0, p, v1);
    mat_mul(16, v1, v2);
    w_div(v2);
    mat_mul(32, v2, v3);
    w_div(v3);
    wd = (fmt_w == 0) ? 66'sd1 : 66'($unsigned(fmt_w));
    ht = (fmt_h == 0) ? 66'sd1 : 66'($unsigned(fmt_h));
    res.u = sat(66'(v3[0]) / wd);
    res.v = sat(66'(v3[1]) / ht);
    res.d = v3[2];
    res.w = v3[3];
    return res;
  endfunction

  function automatic logic signed [31:0] rand_val(input int spread);
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return MAXQ;
          1: return MINQ;
          2: return 0;
          3: return -1;
          default: return Q1;
        endcase
      end
      default: return $signed($urandom_range(0, 2 * spread)) - spread;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_w();
    case ($urandom_range(9))
      0: return 0;
      1, 2: return $urandom;
      default: return Q1 + $signed($urandom_range(0, Q1)) - Q1 / 2;
    endcase
  endfunction

  function automatic row_t mk_row(input logic cmd, input logic [5:0] idx,
                                  input logic signed [31:0] val,
                                  input logic signed [31:0] x, y, z, w);
    row_t r;
    r.cmd = cmd;
    r.idx = idx;
    r.val = val;
    r.pos[0] = x;
    r.pos[1] = y;
    r.pos[2] = z;
    r.pos[3] = w;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic row_t mk_typed(input logic signed [31:0] x, y, z, w,
                                    input logic signed [31:0] eu, ev, ed, ew);
    row_t r;
    r = mk_row(ppuv_pkg::CMD_XFORM, 6'd0, 0, x, y, z, w);
    r.typed = 1'b1;
    r.want.u = eu;
    r.want.v = ev;
    r.want.d = ed;
    r.want.w = ew;
    return r;
  endfunction

  // send one word, update the predictor once it is taken
  task automatic send_word(input row_t r);
    while ($urandom_range(99) < tx_idle) begin
      pix_in_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in_if.valid <= 1'b1;
    pix_in_if.command <= r.cmd;
    pix_in_if.coef_index <= r.idx;
    pix_in_if.coef_value <= r.val;
    pix_in_if.pos_x <= r.pos[0];
    pix_in_if.pos_y <= r.pos[1];
    pix_in_if.pos_z <= r.pos[2];
    pix_in_if.pos_w <= r.pos[3];
    @(posedge clk);
    while (!pix_in_if.ready) @(posedge clk);
    if (r.cmd == ppuv_pkg::CMD_LOAD) begin
      if (r.idx < 48) coef_mem[r.idx] = r.val;
    end else if (r.typed) begin
      pending_uv.push_back(r.want);
    end else begin
      pending_uv.push_back(project_pos(r.pos));
    end
  endtask

  task automatic drain();
    pix_in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_uv.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_fmt(input logic [15:0] wv, input logic [15:0] hv);
    cfg_we <= 1'b1;
    cfg_addr <= ppuv_pkg::REG_FORMAT_WIDTH;
    cfg_data <= wv;
    @(posedge clk);
    cfg_addr <= ppuv_pkg::REG_FORMAT_HEIGHT;
    cfg_data <= hv;
    @(posedge clk);
    cfg_we <= 1'b0;
    fmt_w = wv;
    fmt_h = hv;
  endtask

  task automatic run_random(input int count);
    row_t r;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 12) begin
        r = mk_row(ppuv_pkg::CMD_LOAD, 6'($urandom_range(63)), rand_val(2 * Q1),
                   $urandom, $urandom, $urandom, $urandom);
      end else begin
        r = mk_row(ppuv_pkg::CMD_XFORM, 6'($urandom_range(63)), $urandom,
                   rand_val(8 * Q1), rand_val(8 * Q1), rand_val(8 * Q1), rand_w());
      end
      send_word(r);
    end
  endtask

  // output side: random ready, compare against the oldest expectation
  always @(posedge clk) begin
    uv_t e;
    if (rst) begin
      uv_out_if.ready <= 1'b0;
    end else begin
      uv_out_if.ready <= ($urandom_range(99) >= rx_idle);
      if (uv_out_if.valid && uv_out_if.ready) begin
        if (pending_uv.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word u=%0d", uv_out_if.out_u);
        end else begin
          e = pending_uv.pop_front();
          if (uv_out_if.out_u !== e.u || uv_out_if.out_v !== e.v ||
              uv_out_if.out_depth !== e.d || uv_out_if.out_weight !== e.w) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %h %h %h %h got %h %h %h %h", e.u, e.v, e.d, e.w,
                       uv_out_if.out_u, uv_out_if.out_v, uv_out_if.out_depth,
                       uv_out_if.out_weight);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = ppuv_pkg::REG_FORMAT_WIDTH;
    cfg_data = '0;
    pix_in_if.valid = 1'b0;
    pix_in_if.command = ppuv_pkg::CMD_LOAD;
    pix_in_if.coef_index = '0;
    pix_in_if.coef_value = '0;
    pix_in_if.pos_x = '0;
    pix_in_if.pos_y = '0;
    pix_in_if.pos_z = '0;
    pix_in_if.pos_w = '0;
    mismatches = 0;
    tx_idle = 24;
    rx_idle = 80;
    for (int i = 0; i < 48; i++) coef_mem[i] = (i % 16) % 5 == 0 ? Q1 : 0;
    fmt_w = 16'd1;
    fmt_h = 16'd1;

    // identity matrices after reset
    dir_rows.push_back(mk_typed(2 * Q1, 3 * Q1, 4 * Q1, Q1, 2 * Q1, 3 * Q1, 4 * Q1, Q1));
    // zero w skips both divides
    dir_rows.push_back(mk_typed(5, 6, 7, 0, 5, 6, 7, 0));
    dir_rows.push_back(mk_typed(MAXQ, MAXQ, MAXQ, Q1, MAXQ, MAXQ, MAXQ, Q1));
    dir_rows.push_back(mk_typed(MINQ, MINQ, MINQ, Q1, MINQ, MINQ, MINQ, Q1));
    dir_rows.push_back(mk_typed(Q1, Q1, Q1, 2 * Q1, Q1 / 2, Q1 / 2, Q1 / 2, Q1));
    dir_rows.push_back(mk_typed(Q1, -Q1, 0, -Q1, -Q1, Q1, 0, Q1));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_XFORM, 6'd63, MAXQ, MAXQ, MINQ, 0, 1));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_XFORM, 6'd0, 0, MINQ, MAXQ, -1, -1));
    // loads above the last slot are dropped
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_LOAD, 6'd48, 12345, MAXQ, MAXQ, MAXQ, MAXQ));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_LOAD, 6'd63, MINQ, 0, 0, 0, 0));
    dir_rows.push_back(mk_typed(2 * Q1, 3 * Q1, 4 * Q1, Q1, 2 * Q1, 3 * Q1, 4 * Q1, Q1));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_LOAD, 6'd0, 2 * Q1, MINQ, MINQ, MINQ, MINQ));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_LOAD, 6'd21, Q1 / 2, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_LOAD, 6'd31, 3 * Q1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_LOAD, 6'd35, 7 * Q1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_XFORM, 6'd5, MAXQ, Q1, 2 * Q1, 3 * Q1, Q1));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_XFORM, 6'd0, 0, MAXQ, MAXQ, MAXQ, 1));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_LOAD, 6'd16, MAXQ, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_LOAD, 6'd47, MINQ, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_XFORM, 6'd0, 0, Q1, -Q1, Q1, 3));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_XFORM, 6'd0, 0, MINQ, MINQ, MINQ, MINQ));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_LOAD, 6'd16, Q1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_LOAD, 6'd47, Q1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ppuv_pkg::CMD_XFORM, 6'd0, 0, 5 * Q1, -9 * Q1, Q1, Q1 / 4));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i]);
    drain();
    write_fmt(16'd1920, 16'd1080);
    run_random(140);
    drain();
    write_fmt(16'd0, 16'd65535);
    tx_idle = 80;
    rx_idle = 24;
    run_random(140);
    drain();
    write_fmt(16'd65535, 16'd0);
    run_random(140);
    drain();
    write_fmt(16'd3, 16'd1);
    tx_idle = 0;
    rx_idle = 0;
    run_random(140);
    drain();
    write_fmt(16'd1, 16'd7);
    run_random(140);
    drain();
    write_fmt(16'($urandom), 16'($urandom));
    run_random(140);
    drain();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
